// ----- rtl/core/volume_axis_projection_macros.svh -----
// -----------------------------------------------------------------------------
// volume_axis_projection assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled during rst_ni low.
// -----------------------------------------------------------------------------
`ifndef VOLUME_AXIS_PROJECTION_MACROS_SVH
`define VOLUME_AXIS_PROJECTION_MACROS_SVH

`ifndef SYNTHESIS
// property must hold on every clock edge out of reset
`define VAP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
// expression must never be true out of reset
`define VAP_ASSERT_NEVER(label, expr) \
  `VAP_ASSERT(label, !(expr))
`else
`define VAP_ASSERT(label, prop)
`define VAP_ASSERT_NEVER(label, expr)
`endif

`endif

// ----- rtl/core/vap_pkg.sv -----
// -----------------------------------------------------------------------------
// vap_pkg
// Shared constants, codes and types of the volume axis projection block.
// -----------------------------------------------------------------------------
package vap_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int MAX_DEPTH  = 32;

  // longest voxel line along any axis
  localparam int LINE_MAX = 32;

  localparam int DIM_W  = 6;                      // config dimension field
  localparam int IDX_W  = $clog2(LINE_MAX);       // index inside one line
  localparam int CNT_W  = IDX_W + 1;              // count up to LINE_MAX
  localparam int PIX_W  = 2 * IDX_W;              // projected pixel index
  localparam int TOT_W  = PIX_W + 1;              // pixel count
  localparam int ADDR_W = 3 * IDX_W;              // voxel address
  localparam int VOL_W  = ADDR_W + 1;             // voxel count
  localparam int VOX_W  = 8;
  localparam int SUM_W  = VOX_W + IDX_W;          // line sum
  localparam int DIV_W  = SUM_W;                  // divider dividend/quotient

  localparam int VOX_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(32);
  localparam logic [VOX_W-1:0] VOX_MAX   = VOX_W'(255);

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_EMIT   = 2'd1,
    FUNC_REWIND = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [1:0] {
    MODE_MIN    = 2'd0,
    MODE_MAX    = 2'd1,
    MODE_MEAN   = 2'd2,
    MODE_MEDIAN = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_AXIS   = 3'd0,
    CFG_MODE   = 3'd1,
    CFG_WIDTH  = 3'd2,
    CFG_HEIGHT = 3'd3,
    CFG_DEPTH  = 3'd4
  } cfg_idx_e;

  // divider result bundle
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIM_W-1:0] rem;
  } vap_div_res_t;

  // 0 acts as 1, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(maxv)) begin
      r = DIM_W'(maxv);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/vap_div.sv -----
// -----------------------------------------------------------------------------
// vap_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// pixel index split and the line mean.
// -----------------------------------------------------------------------------
module vap_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vap_pkg::DIV_W-1:0]  dividend_i,
  input  logic [vap_pkg::DIM_W-1:0]  divisor_i,
  output vap_pkg::vap_div_res_t      res_o
);
  import vap_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DIM_W:0]    rem_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DIM_W-1:0]  dsr_q;

  logic [DIM_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem_q[DIM_W-1:0], quo_q[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q[DIM_W-1:0];

endmodule

// ----- rtl/core/volume_axis_projection.sv -----
// -----------------------------------------------------------------------------
// volume_axis_projection
// Loads an 8-bit volume one voxel per command, then emits a min, max, mean
// or median projection along x, y or z, one pixel per command.
// -----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------
//  command   | start_i / busy_o     | func_i, voxel_value_i
//  result    | done_o (1-cycle)     | proj_pixel_o, row_end_o, last_pixel_o
//  config    | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
//  Steps: a load word does two multiplies for the volume size, then the
//  store write; rewind and the unused code finish on acceptance. An emit
//  word splits the pixel index with the divider, then walks the line
//  through the voxel store read port, then divides the line sum for the
//  mean, or runs the rank loop for the median on the single read port of
//  the line buffer. busy_o stays high until the result cycle is over.
//  Reset clears control, config and pointers; the voxel store holds garbage
//  until written and has no clearing pass. The result strobe cannot be held.
// -----------------------------------------------------------------------------
`include "volume_axis_projection_macros.svh"

module volume_axis_projection (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  func_i,
  input  logic [vap_pkg::VOX_W-1:0]   voxel_value_i,
  // result
  output logic                        done_o,
  output logic [vap_pkg::VOX_W-1:0]   proj_pixel_o,
  output logic                        row_end_o,
  output logic                        last_pixel_o,
  // config
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [vap_pkg::DIM_W-1:0]   cfg_wdata_i
);
  import vap_pkg::*;

  // sequencer, one-hot
  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_LD_MUL  = 15'b000000000000010,
    S_LD_VOL  = 15'b000000000000100,
    S_LD_WR   = 15'b000000000001000,
    S_EM_TOT  = 15'b000000000010000,
    S_EM_PTR  = 15'b000000000100000,
    S_DIV     = 15'b000000001000000,
    S_BASE1   = 15'b000000010000000,
    S_BASE2   = 15'b000000100000000,
    S_WALK    = 15'b000001000000000,
    S_MEAN    = 15'b000010000000000,
    S_RK_CAND = 15'b000100000000000,
    S_RK_LOAD = 15'b001000000000000,
    S_RK_CMP  = 15'b010000000000000,
    S_OUT     = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [1:0]       axis_q;
  logic [1:0]       mode_q;
  logic [DIM_W-1:0] width_q, height_q, depth_q;

  // pointers
  logic [ADDR_W-1:0] load_ptr_q;
  logic [PIX_W-1:0]  emit_ptr_q;

  // datapath
  logic [VOX_W-1:0]  voxel_q;
  logic [TOT_W-1:0]  mul_q;
  logic [VOL_W-1:0]  vol_q;
  logic [TOT_W-1:0]  total_q;
  logic [TOT_W-1:0]  step_q;
  logic [PIX_W-1:0]  pix_q;
  logic [IDX_W-1:0]  r_q, c_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  iss_q, ret_q;
  logic              rd_vld_q;
  logic [VOX_W-1:0]  mn_q, mx_q;
  logic [SUM_W-1:0]  sum_q;
  logic [VOX_W-1:0]  res_q;
  logic              row_end_q, last_q;
  logic [CNT_W-1:0]  ci_q, rj_q;
  logic              lv_q;
  logic [VOX_W-1:0]  cand_q;
  logic [CNT_W-1:0]  lt_q, le_q;

  // memories
  logic [VOX_W-1:0]  vox_mem [VOX_DEPTH];
  logic [VOX_W-1:0]  vox_rdata_q;
  logic [VOX_W-1:0]  lbuf [LINE_MAX];
  logic [VOX_W-1:0]  lb_rdata_q;

  // ---------------------------------------------------------------------------
  // Decoded dimensions and line geometry
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] w, h, d;
  logic             ax_x, ax_y;
  logic [DIM_W-1:0] rows, cols, len;
  logic [CNT_W-1:0] k_med;

  assign w = clamp_dim(width_q,  MAX_WIDTH);
  assign h = clamp_dim(height_q, MAX_HEIGHT);
  assign d = clamp_dim(depth_q,  MAX_DEPTH);

  // axis code 3 falls through to z
  assign ax_x = (axis_q == AXIS_X);
  assign ax_y = (axis_q == AXIS_Y);

  always_comb begin
    if (ax_x) begin
      rows = h; cols = d; len = w;
    end else if (ax_y) begin
      rows = w; cols = d; len = h;
    end else begin
      rows = h; cols = w; len = d;
    end
  end

  assign k_med = CNT_W'(len >> 1);

  // ---------------------------------------------------------------------------
  // Command accept and pointer selection
  // ---------------------------------------------------------------------------
  logic              accept;
  logic [ADDR_W-1:0] ld_sel;
  logic [VOL_W-1:0]  ld_nxt;
  logic [PIX_W-1:0]  em_sel;
  logic [TOT_W-1:0]  em_nxt;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // a pointer left past the end by a size change restarts at zero
  assign ld_sel = ({1'b0, load_ptr_q} >= vol_q) ? '0 : load_ptr_q;
  assign ld_nxt = VOL_W'(ld_sel) + 1'b1;
  assign em_sel = ({1'b0, emit_ptr_q} >= total_q) ? '0 : emit_ptr_q;
  assign em_nxt = TOT_W'(pix_q) + 1'b1;

  // ---------------------------------------------------------------------------
  // Line walk and rank compare terms
  // ---------------------------------------------------------------------------
  logic             vox_re, vox_we;
  logic             walk_last;
  logic [VOX_W-1:0] mn_n, mx_n;
  logic [SUM_W-1:0] sum_n;
  logic [CNT_W-1:0] lt_n, le_n;
  logic             rank_last, rank_hit;
  logic [IDX_W-1:0] lb_raddr;

  assign vox_we    = (state_q == S_LD_WR);
  assign vox_re    = (state_q == S_WALK) && (iss_q < CNT_W'(len));
  assign walk_last = (state_q == S_WALK) && rd_vld_q
                     && (CNT_W'(ret_q + 1'b1) == CNT_W'(len));

  assign mn_n  = (vox_rdata_q < mn_q) ? vox_rdata_q : mn_q;
  assign mx_n  = (vox_rdata_q > mx_q) ? vox_rdata_q : mx_q;
  assign sum_n = sum_q + SUM_W'(vox_rdata_q);

  // candidate is the median when lt <= k < le over the whole line
  assign lt_n      = lt_q + CNT_W'(lb_rdata_q <  cand_q);
  assign le_n      = le_q + CNT_W'(lb_rdata_q <= cand_q);
  assign rank_last = (state_q == S_RK_CMP) && lv_q && (rj_q == CNT_W'(len));
  assign rank_hit  = (lt_n <= k_med) && (k_med < le_n);

  assign lb_raddr = (state_q == S_RK_CAND) ? ci_q[IDX_W-1:0] : rj_q[IDX_W-1:0];

  // ---------------------------------------------------------------------------
  // Shared divider: pixel index / cols, then line sum / len for the mean
  // ---------------------------------------------------------------------------
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIM_W-1:0] div_divisor;
  vap_div_res_t     div_res;

  assign div_start    = (state_q == S_EM_PTR) || (walk_last && (mode_q == MODE_MEAN));
  assign div_dividend = (state_q == S_EM_PTR) ? DIV_W'(em_sel) : DIV_W'(sum_n);
  assign div_divisor  = (state_q == S_EM_PTR) ? cols : len;

  vap_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .res_o      (div_res)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_LOAD: state_d = S_LD_MUL;
            FUNC_EMIT: state_d = S_EM_TOT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_LD_MUL:  state_d = S_LD_VOL;
      S_LD_VOL:  state_d = S_LD_WR;
      S_LD_WR:   state_d = S_IDLE;
      S_EM_TOT:  state_d = S_EM_PTR;
      S_EM_PTR:  state_d = S_DIV;
      S_DIV:     if (div_res.done) state_d = S_BASE1;
      S_BASE1:   state_d = S_BASE2;
      S_BASE2:   state_d = S_WALK;
      S_WALK: begin
        if (walk_last) begin
          case (mode_q)
            MODE_MEAN:   state_d = S_MEAN;
            MODE_MEDIAN: state_d = S_RK_CAND;
            default:     state_d = S_OUT;
          endcase
        end
      end
      S_MEAN:    if (div_res.done) state_d = S_OUT;
      S_RK_CAND: state_d = S_RK_LOAD;
      S_RK_LOAD: state_d = S_RK_CMP;
      S_RK_CMP: begin
        if (rank_last) state_d = rank_hit ? S_OUT : S_RK_CAND;
      end
      S_OUT:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      axis_q     <= AXIS_Z;
      mode_q     <= MODE_MAX;
      width_q    <= DIM_RESET;
      height_q   <= DIM_RESET;
      depth_q    <= DIM_RESET;
      load_ptr_q <= '0;
      emit_ptr_q <= '0;
      rd_vld_q   <= 1'b0;
      lv_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= vox_re;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AXIS:   axis_q   <= cfg_wdata_i[1:0];
          CFG_MODE:   mode_q   <= cfg_wdata_i[1:0];
          CFG_WIDTH:  width_q  <= cfg_wdata_i;
          CFG_HEIGHT: height_q <= cfg_wdata_i;
          CFG_DEPTH:  depth_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (accept && (func_i == FUNC_REWIND)) begin
        load_ptr_q <= '0;
        emit_ptr_q <= '0;
      end

      if (state_q == S_LD_WR) begin
        load_ptr_q <= (ld_nxt >= vol_q) ? '0 : ld_nxt[ADDR_W-1:0];
      end

      if (state_q == S_OUT) begin
        emit_ptr_q <= (em_nxt >= total_q) ? '0 : em_nxt[PIX_W-1:0];
      end

      if (state_q == S_RK_LOAD) begin
        lv_q <= 1'b0;
      end else if (state_q == S_RK_CMP) begin
        lv_q <= (rj_q < CNT_W'(len));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) voxel_q <= voxel_value_i;
      end
      S_LD_MUL: mul_q <= TOT_W'(w) * TOT_W'(h);
      S_LD_VOL: vol_q <= VOL_W'(mul_q) * VOL_W'(d);
      S_EM_TOT: total_q <= TOT_W'(rows) * TOT_W'(cols);
      S_EM_PTR: begin
        // address stride along the collapsed axis
        if (ax_x) begin
          step_q <= TOT_W'(1);
        end else if (ax_y) begin
          step_q <= TOT_W'(w);
        end else begin
          step_q <= TOT_W'(w) * TOT_W'(h);
        end
        pix_q <= em_sel;
      end
      S_DIV: begin
        if (div_res.done) begin
          r_q       <= div_res.quot[IDX_W-1:0];
          c_q       <= div_res.rem[IDX_W-1:0];
          row_end_q <= (div_res.rem == cols - 1'b1);
          last_q    <= (TOT_W'(pix_q) == total_q - 1'b1);
        end
      end
      S_BASE1: begin
        if (ax_x || ax_y) begin
          mul_q <= TOT_W'(c_q) * TOT_W'(h);
        end else begin
          mul_q <= TOT_W'(r_q) * TOT_W'(w);
        end
      end
      S_BASE2: begin
        // start of the line: x -> (c*h + r)*w, y -> c*h*w + r, z -> r*w + c
        if (ax_x || ax_y) begin
          addr_q <= ADDR_W'((ADDR_W'(mul_q) + (ax_x ? ADDR_W'(r_q) : '0)) * ADDR_W'(w))
                    + (ax_y ? ADDR_W'(r_q) : '0);
        end else begin
          addr_q <= ADDR_W'(mul_q) + ADDR_W'(c_q);
        end
        iss_q <= '0;
        ret_q <= '0;
        mn_q  <= VOX_MAX;
        mx_q  <= '0;
        sum_q <= '0;
      end
      S_WALK: begin
        if (vox_re) begin
          addr_q <= addr_q + ADDR_W'(step_q);
          iss_q  <= iss_q + 1'b1;
        end
        if (rd_vld_q) begin
          mn_q  <= mn_n;
          mx_q  <= mx_n;
          sum_q <= sum_n;
          ret_q <= ret_q + 1'b1;
        end
        if (walk_last) begin
          res_q <= (mode_q == MODE_MIN) ? mn_n : mx_n;
          ci_q  <= '0;
        end
      end
      S_MEAN: begin
        if (div_res.done) res_q <= div_res.quot[VOX_W-1:0];
      end
      S_RK_LOAD: begin
        cand_q <= lb_rdata_q;
        lt_q   <= '0;
        le_q   <= '0;
        rj_q   <= '0;
      end
      S_RK_CMP: begin
        if (rj_q < CNT_W'(len)) rj_q <= rj_q + 1'b1;
        if (lv_q) begin
          lt_q <= lt_n;
          le_q <= le_n;
        end
        if (rank_last) begin
          if (rank_hit) res_q <= cand_q;
          ci_q <= ci_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // voxel store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (vox_we) vox_mem[ld_sel] <= voxel_q;
    if (vox_re) vox_rdata_q <= vox_mem[addr_q];
  end

  // line buffer for the median rank pass
  always_ff @(posedge clk_i) begin
    if ((state_q == S_WALK) && rd_vld_q) lbuf[ret_q[IDX_W-1:0]] <= vox_rdata_q;
    lb_rdata_q <= lbuf[lb_raddr];
  end

  // ---------------------------------------------------------------------------
  // Result port
  // ---------------------------------------------------------------------------
  assign done_o       = (state_q == S_OUT);
  assign proj_pixel_o = res_q;
  assign row_end_o    = row_end_q;
  assign last_pixel_o = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `VAP_ASSERT(a_done_single, done_o |=> !done_o)
  `VAP_ASSERT(a_load_busy, (accept && (func_i == FUNC_LOAD)) |=> busy_o)
  `VAP_ASSERT(a_div_owner, div_res.done |-> (state_q == S_DIV || state_q == S_MEAN))
  `VAP_ASSERT(a_walk_order, (state_q == S_WALK) |-> (ret_q <= iss_q))
  `VAP_ASSERT(a_pix_range, (state_q == S_OUT) |-> (TOT_W'(pix_q) < total_q))
  `VAP_ASSERT_NEVER(a_rank_overrun, (state_q == S_RK_CAND) && (ci_q >= CNT_W'(len)))

endmodule
